// ===== hw/rtl/tccs_pkg.sv =====
// Shared types and constants for the text console cursor/scroll core.
// Used by tccs_ctrl, tccs_dp and text_console_cursor_scroll_core.
`default_nettype none

package tccs_pkg;

  // Stream payload widths
  localparam int IN_W   = 32;
  localparam int USER_W = 2;
  localparam int OUT_W  = 32;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;
  localparam int CH_W   = 8;
  localparam int ATTR_W = 8;

  // Character codes
  localparam logic [CH_W-1:0] CH_BS    = 8'h08;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TILDE = 8'h7E;

  localparam logic [CELL_W-1:0] BLANK_CELL       = 16'h0020;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RST = 8'h07;

  typedef enum logic [USER_W-1:0] {
    KIND_PUT_CHAR = 2'd0,
    KIND_PUT_AT   = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_READ     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_item;
    logic exec;
    logic clear_step;
    logic scroll_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  scroll_req;
    logic  sweep_last;
    logic  out_free;
  } dp_sts_t;

endpackage : tccs_pkg

`default_nettype wire

// ===== hw/rtl/tccs_ctrl.sv =====
// Sequencer for the console core: accepts a request, runs it, sweeps the
// cell store on clear/scroll/reset and hands the response over.
// Depends on tccs_pkg.
`default_nettype none

module tccs_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  output logic                  s_ready_o,
  input  tccs_pkg::dp_sts_t     sts_i,
  output tccs_pkg::dp_cmd_t     cmd_o
);
  import tccs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      ST_INIT: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        case (sts_i.kind)
          KIND_PUT_CHAR: state_d = sts_i.scroll_req ? ST_SCROLL : ST_DONE;
          KIND_CLEAR:    state_d = ST_CLEAR;
          default:       state_d = ST_DONE;
        endcase
      end
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.sweep_last) state_d = ST_DONE;
      end
      ST_SCROLL: begin
        cmd_o.scroll_step = 1'b1;
        if (sts_i.sweep_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

endmodule : tccs_ctrl

`default_nettype wire

// ===== hw/rtl/tccs_dp.sv =====
// Datapath of the console core: cell store, cursor, sweep counter,
// request and response registers, default attribute register.
// Depends on tccs_pkg.
`default_nettype none

module tccs_dp #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  tccs_pkg::dp_cmd_t                cmd_i,
  output tccs_pkg::dp_sts_t                sts_o,
  input  wire logic [tccs_pkg::IN_W-1:0]   s_tdata_i,
  input  wire logic [tccs_pkg::USER_W-1:0] s_tuser_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [tccs_pkg::ATTR_W-1:0] cfg_wdata_i,
  input  wire logic                        m_ready_i,
  output logic                             m_valid_o,
  output logic [tccs_pkg::POS_W-1:0]       m_pos_o,
  output logic [tccs_pkg::CELL_W-1:0]      m_cell_o
);
  import tccs_pkg::*;

  localparam int NCELLS = COLS * ROWS;
  localparam int COPY_N = NCELLS - COLS;
  localparam int AW     = $clog2(NCELLS);
  localparam int SW     = $clog2(NCELLS + 1);
  localparam int CW     = $clog2(COLS);
  localparam int CW1    = $clog2(COLS + TAB_STOP);
  localparam int RW     = $clog2(ROWS);
  localparam int RW1    = $clog2(ROWS + 1);

  // cell store
  logic [CELL_W-1:0] mem [NCELLS];
  logic [CELL_W-1:0] rd_q;
  logic              we, re;
  logic [AW-1:0]     wa, ra;
  logic [CELL_W-1:0] wd;

  // request registers
  kind_e             kind_q;
  logic [CH_W-1:0]   ch_q;
  logic [7:0]        col_q, row_q;
  logic [ATTR_W-1:0] attr_q;

  logic [ATTR_W-1:0] dflt_attr_q;
  logic [CW-1:0]     cur_col_q, cur_col_d;
  logic [RW-1:0]     cur_row_q, cur_row_d;
  logic [SW-1:0]     sw_q, sw_d;

  logic              out_valid_q;
  logic [POS_W-1:0]  out_pos_q;
  logic [CELL_W-1:0] out_cell_q;

  // next tab stop for each column
  logic [CW1-1:0] tab_lut [COLS];
  for (genvar g = 0; g < COLS; g++) begin : g_tab
    assign tab_lut[g] = CW1'(g + TAB_STOP - (g % TAB_STOP));
  end

  logic          in_bounds, printable, scroll, sweep_last;
  logic [AW-1:0] pos_lin, item_addr;
  logic [CW1-1:0] col_a, col_b;
  logic [RW1-1:0] row_a, row_b;

  assign in_bounds = (32'(col_q) < COLS) && (32'(row_q) < ROWS);
  assign printable = (ch_q >= CH_SPACE) && (ch_q <= CH_TILDE);
  assign pos_lin   = AW'(cur_col_q) + AW'(cur_row_q * COLS);
  assign item_addr = AW'(col_q) + AW'(row_q * COLS);

  // cursor motion for a streamed character
  always_comb begin
    col_a = CW1'(cur_col_q);
    row_a = RW1'(cur_row_q);
    case (ch_q)
      CH_BS:  if (cur_col_q != '0) col_a = CW1'(cur_col_q) - 1'b1;
      CH_LF: begin
        col_a = '0;
        row_a = RW1'(cur_row_q) + 1'b1;
      end
      CH_CR:  col_a = '0;
      CH_TAB: col_a = tab_lut[cur_col_q];
      default: if (printable) col_a = CW1'(cur_col_q) + 1'b1;
    endcase
    if (col_a >= CW1'(COLS)) begin
      col_b = '0;
      row_b = row_a + 1'b1;
    end else begin
      col_b = col_a;
      row_b = row_a;
    end
  end

  assign scroll = (row_b >= RW1'(ROWS));

  assign sweep_last = cmd_i.scroll_step ? (sw_q == SW'(NCELLS))
                                        : (sw_q == SW'(NCELLS - 1));

  // store port selection
  always_comb begin
    we = 1'b0;
    wa = pos_lin;
    wd = {dflt_attr_q, ch_q};
    re = 1'b0;
    ra = item_addr;
    if (cmd_i.clear_step) begin
      we = 1'b1;
      wa = sw_q[AW-1:0];
      wd = BLANK_CELL;
    end else if (cmd_i.scroll_step) begin
      // read row below, write one step behind; bottom row gets blanks
      re = (sw_q < SW'(COPY_N));
      ra = AW'(32'(sw_q) + COLS);
      we = (sw_q != '0);
      wa = AW'(32'(sw_q) - 1);
      wd = (sw_q <= SW'(COPY_N)) ? rd_q : BLANK_CELL;
    end else if (cmd_i.exec) begin
      case (kind_q)
        KIND_PUT_CHAR: we = printable;
        KIND_PUT_AT: begin
          we = in_bounds;
          wa = item_addr;
          wd = {attr_q, ch_q};
        end
        KIND_READ: re = 1'b1;
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  always_comb begin
    sw_d = sw_q;
    if (cmd_i.clear_step || cmd_i.scroll_step) begin
      sw_d = sweep_last ? '0 : sw_q + 1'b1;
    end
  end

  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (cmd_i.exec) begin
      case (kind_q)
        KIND_PUT_CHAR: begin
          cur_col_d = CW'(col_b);
          cur_row_d = scroll ? RW'(ROWS - 1) : RW'(row_b);
        end
        KIND_CLEAR: begin
          cur_col_d = '0;
          cur_row_d = '0;
        end
        default: cur_col_d = cur_col_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      sw_q        <= '0;
      dflt_attr_q <= DEFAULT_ATTR_RST;
      out_valid_q <= 1'b0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      sw_q      <= sw_d;
      if (cfg_we_i) dflt_attr_q <= cfg_wdata_i;
      if (cmd_i.out_load)  out_valid_q <= 1'b1;
      else if (m_ready_i)  out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= kind_e'(s_tuser_i);
      ch_q   <= s_tdata_i[7:0];
      col_q  <= s_tdata_i[15:8];
      row_q  <= s_tdata_i[23:16];
      attr_q <= {s_tdata_i[31:28], s_tdata_i[27:24]};
    end
    if (cmd_i.out_load) begin
      out_pos_q  <= POS_W'(pos_lin);
      out_cell_q <= ((kind_q == KIND_READ) && in_bounds) ? rd_q : '0;
    end
  end

  assign sts_o.kind       = kind_q;
  assign sts_o.scroll_req = scroll;
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_free   = !out_valid_q || m_ready_i;

  assign m_valid_o = out_valid_q;
  assign m_pos_o   = out_pos_q;
  assign m_cell_o  = out_cell_q;

endmodule : tccs_dp

`default_nettype wire

// ===== hw/rtl/text_console_cursor_scroll_core.sv =====
// Top level of the text console core: stream ports, controller and datapath.
// Depends on tccs_pkg, tccs_ctrl and tccs_dp.
//
// Channel   Dir  Contents
// s_axis    in   request: tuser = kind, tdata = char/col/row/fg/bg
// m_axis    out  response: tdata = cursor_pos, cell_data
// cfg       in   default attribute for streamed printable characters
//
// A request is taken in ST_IDLE, executed in ST_EXEC and its response is
// loaded into the output register in ST_DONE; put at, read and a put char
// that does not scroll take no other state. The cell store has one write
// and one read port, so the sweeps run one cell per cycle: clear adds a
// sweep of the store, a scroll one that copies a row up and blanks the
// bottom row. After reset the store is blanked with s_axis_tready low.
// A response waiting on m_axis does not block taking the next request; that
// request stalls only at its own response load until the output frees up.
`default_nettype none

module text_console_cursor_scroll_core #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] char_code, [15:8] col, [23:16] row, [27:24] fg_color, [31:28] bg_color
  input  wire logic [tccs_pkg::IN_W-1:0]   s_axis_tdata,
  // [1:0] kind
  input  wire logic [tccs_pkg::USER_W-1:0] s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [10:0] cursor_pos, [26:11] cell_data, [31:27] zero
  output logic [tccs_pkg::OUT_W-1:0]       m_axis_tdata,
  input  wire logic                        cfg_we_i,
  input  wire logic [tccs_pkg::ATTR_W-1:0] cfg_wdata_i
);
  import tccs_pkg::*;

  localparam int NCELLS = COLS * ROWS;

  dp_cmd_t           cmd;
  dp_sts_t           sts;
  logic [POS_W-1:0]  pos;
  logic [CELL_W-1:0] cell_word;

  tccs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tccs_dp #(
    .COLS     (COLS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_pos_o     (pos),
    .m_cell_o    (cell_word)
  );

  assign m_axis_tdata = {(OUT_W - POS_W - CELL_W)'(0), cell_word, pos};

  // one request in flight: ready drops right after a request is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  // a response is only loaded while the core is busy with a request
  a_resp_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("response appeared without a request being executed");

  // reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (NCELLS <= (1 << POS_W)) && m_axis_tvalid |->
      32'(m_axis_tdata[POS_W-1:0]) < NCELLS)
    else $error("cursor position off screen");

endmodule : text_console_cursor_scroll_core

`default_nettype wire
